@@ hw/rtl/strided_slice_address_gen_assert.svh @@
// ---------------------------------------------------------------------------
// Strided slice address generator assertion macros
// Clocked assertion helpers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef STRIDED_SLICE_ADDRESS_GEN_ASSERT_SVH
`define STRIDED_SLICE_ADDRESS_GEN_ASSERT_SVH

// A property checked at every rising clock edge outside reset.
`define SSAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define SSAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ssag_pkg.sv @@
// ---------------------------------------------------------------------------
// Strided slice address generator package
// Shared constants, command codes, types and lane helpers.
// ---------------------------------------------------------------------------
package ssag_pkg;

  localparam int MAX_RANK = 4;
  localparam int DIM_BITS = 16;
  localparam int LANES    = 4;
  localparam int LANE_W   = 16;
  localparam int AXIS_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RANK_W   = 3;
  localparam int CNT_W    = DIM_BITS + 1;
  localparam int NORM_W   = DIM_BITS + 2;
  localparam int ADDR_W   = 32;
  localparam int CFG_AW   = 6;
  localparam int CFG_DW   = 64;
  localparam int MASK_W   = 4;
  localparam int ERR_W    = 2;
  localparam int OP_W     = 4;

  localparam logic [ERR_W-1:0] ERR_OK          = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ZERO_STRIDE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY       = 2'd2;

  localparam logic [2:0] REG_DIMS     = 3'd0;
  localparam logic [2:0] REG_STARTS   = 3'd1;
  localparam logic [2:0] REG_ENDS     = 3'd2;
  localparam logic [2:0] REG_STRIDES  = 3'd3;
  localparam logic [2:0] REG_COLLAPSE = 3'd4;
  localparam logic [2:0] REG_RANK     = 3'd5;

  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_W-1:0] OP_INIT  = 4'd1;
  localparam logic [OP_W-1:0] OP_NORM  = 4'd2;
  localparam logic [OP_W-1:0] OP_CLAMP = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL1  = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL2  = 4'd6;
  localparam logic [OP_W-1:0] OP_MUL3  = 4'd7;
  localparam logic [OP_W-1:0] OP_MUL4  = 4'd8;
  localparam logic [OP_W-1:0] OP_DONE  = 4'd9;
  localparam logic [OP_W-1:0] OP_EMIT  = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [AXIS_W-1:0] axis;
  } ssag_cmd_t;

  typedef struct packed {
    logic [AXIS_W-1:0] top_axis;
  } ssag_stat_t;

  typedef struct packed {
    logic [CFG_DW-1:0] dims;
    logic [CFG_DW-1:0] starts;
    logic [CFG_DW-1:0] ends;
    logic [CFG_DW-1:0] strides;
    logic [MASK_W-1:0] collapse;
    logic [RANK_W-1:0] rank;
  } ssag_cfg_t;

  // Low DIM_BITS bits of one 16-bit lane; axis 0 sits in the top lane.
  function automatic logic [DIM_BITS-1:0] lane_u(input logic [CFG_DW-1:0] r,
                                                 input logic [AXIS_W-1:0] ax);
    logic [LANE_W-1:0] l;
    l = r[(LANES - 1 - int'(ax)) * LANE_W +: LANE_W];
    return l[DIM_BITS-1:0];
  endfunction

  // Rank zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [RANK_W-1:0] rank_eff(input logic [RANK_W-1:0] r);
    logic [RANK_W-1:0] v;
    v = r;
    if (r == '0) v = RANK_W'(1);
    else if (int'(r) > MAX_RANK) v = RANK_W'(MAX_RANK);
    return v;
  endfunction

endpackage

@@ hw/rtl/ssag_regs.sv @@
// ---------------------------------------------------------------------------
// Strided slice configuration registers
// APB-style register file holding the slice description.
// ---------------------------------------------------------------------------
module ssag_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssag_pkg::CFG_AW-1:0]  paddr,
  input  logic [ssag_pkg::CFG_DW-1:0]  pwdata,
  output logic [ssag_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output ssag_pkg::ssag_cfg_t          cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ssag_pkg::CFG_AW-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dims     <= '0;
      cfg.starts   <= '0;
      cfg.ends     <= '0;
      cfg.strides  <= '0;
      cfg.collapse <= '0;
      cfg.rank     <= ssag_pkg::RANK_W'(1);
    end else if (wr) begin
      case (idx)
        ssag_pkg::REG_DIMS:     cfg.dims     <= pwdata;
        ssag_pkg::REG_STARTS:   cfg.starts   <= pwdata;
        ssag_pkg::REG_ENDS:     cfg.ends     <= pwdata;
        ssag_pkg::REG_STRIDES:  cfg.strides  <= pwdata;
        ssag_pkg::REG_COLLAPSE: cfg.collapse <= pwdata[ssag_pkg::MASK_W-1:0];
        ssag_pkg::REG_RANK:     cfg.rank     <= pwdata[ssag_pkg::RANK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ssag_pkg::REG_DIMS:     prdata = cfg.dims;
      ssag_pkg::REG_STARTS:   prdata = cfg.starts;
      ssag_pkg::REG_ENDS:     prdata = cfg.ends;
      ssag_pkg::REG_STRIDES:  prdata = cfg.strides;
      ssag_pkg::REG_COLLAPSE: prdata = ssag_pkg::CFG_DW'(cfg.collapse);
      ssag_pkg::REG_RANK:     prdata = ssag_pkg::CFG_DW'(cfg.rank);
      default:                prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/ssag_ctrl.sv @@
// ---------------------------------------------------------------------------
// Strided slice controller
// Sequences slice setup per axis and handles the request and result handshakes.
// ---------------------------------------------------------------------------
module ssag_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  ssag_pkg::ssag_stat_t stat,
  output ssag_pkg::ssag_cmd_t  cmd
);

  localparam int DIV_CW = $clog2(ssag_pkg::CNT_W);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NORM  = 4'd1;
  localparam logic [3:0] S_CLAMP = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_MUL3  = 4'd6;
  localparam logic [3:0] S_MUL4  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]                  state, state_next;
  logic [ssag_pkg::AXIS_W-1:0] axis, axis_next;
  logic [DIV_CW-1:0]           div_cnt, div_cnt_next;
  logic                        out_valid_next;
  logic                        out_free;
  logic                        accept;

  always_comb begin
    out_free       = !out_valid || !out_stall;
    in_stall       = !((state == S_IDLE) && out_free);
    accept         = in_valid && !in_stall;
    state_next     = state;
    axis_next      = axis;
    div_cnt_next   = div_cnt;
    out_valid_next = out_valid && out_stall;
    cmd.op         = ssag_pkg::OP_NONE;
    cmd.axis       = axis;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (restart) begin
            cmd.op     = ssag_pkg::OP_INIT;
            axis_next  = stat.top_axis;
            state_next = S_NORM;
          end else begin
            cmd.op         = ssag_pkg::OP_EMIT;
            out_valid_next = 1'b1;
          end
        end
      end
      S_NORM: begin
        cmd.op     = ssag_pkg::OP_NORM;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op       = ssag_pkg::OP_CLAMP;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.op       = ssag_pkg::OP_DIV;
        div_cnt_next = div_cnt + DIV_CW'(1);
        if (div_cnt == DIV_CW'(ssag_pkg::CNT_W - 1)) state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.op     = ssag_pkg::OP_MUL1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op     = ssag_pkg::OP_MUL2;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.op     = ssag_pkg::OP_MUL3;
        state_next = S_MUL4;
      end
      S_MUL4: begin
        cmd.op = ssag_pkg::OP_MUL4;
        if (axis == '0) begin
          state_next = S_DONE;
        end else begin
          axis_next  = axis - ssag_pkg::AXIS_W'(1);
          state_next = S_NORM;
        end
      end
      S_DONE: begin
        cmd.op     = ssag_pkg::OP_DONE;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.op         = ssag_pkg::OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ hw/rtl/ssag_dp.sv @@
// ---------------------------------------------------------------------------
// Strided slice datapath
// Axis normalization, count divider, offset setup and the element walker.
// ---------------------------------------------------------------------------
module ssag_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ssag_pkg::ssag_cfg_t           cfg,
  input  ssag_pkg::ssag_cmd_t           cmd,
  output ssag_pkg::ssag_stat_t          stat,
  output logic [ssag_pkg::ADDR_W-1:0]   src_index,
  output logic [ssag_pkg::ADDR_W-1:0]   dst_index,
  output logic                          last,
  output logic [ssag_pkg::ERR_W-1:0]    error
);

  localparam int DB = ssag_pkg::DIM_BITS;
  localparam int NW = ssag_pkg::NORM_W;
  localparam int CW = ssag_pkg::CNT_W;
  localparam int AW = ssag_pkg::ADDR_W;
  localparam int MR = ssag_pkg::MAX_RANK;
  localparam logic signed [NW-1:0] ONE_N  = NW'(1);
  localparam logic signed [NW-1:0] NEG1_N = -NW'(1);
  localparam logic signed [NW-1:0] ZERO_N = '0;

  function automatic logic signed [NW-1:0] clampn(input logic signed [NW-1:0] v,
                                                  input logic signed [NW-1:0] lo,
                                                  input logic signed [NW-1:0] hi);
    logic signed [NW-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // Latched slice description.
  logic [ssag_pkg::RANK_W-1:0] lat_rank;
  logic [ssag_pkg::ERR_W-1:0]  err;
  logic                        err_z, err_e;
  logic [CW-1:0]               count   [MR];
  logic [AW-1:0]               delta   [MR];
  logic [DB-1:0]               counter [MR];
  logic [AW-1:0]               step, rew_sum, base, prod;
  logic [AW-1:0]               src, dst;

  // Per-axis setup registers.
  logic signed [NW-1:0] a_n, e_n, first_r;
  logic [CW-1:0]        dnum, drem;
  logic [DB-1:0]        dsor;

  // Current lane fields.
  logic [DB-1:0]        d_u, a_u, e_u, s_u, m_u;
  logic signed [NW-1:0] dn, sa, se, a1, e1;
  logic                 s_neg, s_zero, nonempty;
  logic signed [NW-1:0] lo, hi, fi, st, span, first_c;
  logic [CW-1:0]        num_c, rem_sh;
  logic                 ge;
  logic [AW-1:0]        first_w, stride_w;

  // Walker signals.
  logic                        found;
  logic [ssag_pkg::AXIS_W-1:0] sel;

  assign stat.top_axis = ssag_pkg::AXIS_W'(ssag_pkg::rank_eff(cfg.rank) -
                                           ssag_pkg::RANK_W'(1));

  always_comb begin
    d_u    = ssag_pkg::lane_u(cfg.dims, cmd.axis);
    a_u    = ssag_pkg::lane_u(cfg.starts, cmd.axis);
    e_u    = ssag_pkg::lane_u(cfg.ends, cmd.axis);
    s_u    = ssag_pkg::lane_u(cfg.strides, cmd.axis);
    s_neg  = s_u[DB-1];
    s_zero = (s_u == '0);
    m_u    = s_neg ? (~s_u + DB'(1)) : s_u;
    dn     = $signed({{(NW-DB){1'b0}}, d_u});
    sa     = $signed({{(NW-DB){a_u[DB-1]}}, a_u});
    se     = $signed({{(NW-DB){e_u[DB-1]}}, e_u});

    // Negative indices wrap by the axis size; an end of -1 walking down
    // means run to index zero and is left alone.
    a1 = (sa < ZERO_N) ? sa + dn : sa;
    e1 = ((se < ZERO_N) && !((se == NEG1_N) && s_neg)) ? se + dn : se;
    if (cfg.collapse[cmd.axis]) e1 = s_neg ? a1 - ONE_N : a1 + ONE_N;

    lo = clampn(a_n, ZERO_N, dn);
    hi = clampn(e_n, ZERO_N, dn);
    fi = clampn(a_n, NEG1_N, dn - ONE_N);
    st = clampn(e_n, NEG1_N, dn - ONE_N);
    if (s_neg) begin
      first_c  = fi;
      span     = fi - st;
      nonempty = fi > st;
    end else begin
      first_c  = lo;
      span     = hi - lo;
      nonempty = (lo < hi) && !s_zero;
    end
    num_c = nonempty ? (span[CW-1:0] + CW'(m_u) - CW'(1)) : '0;

    rem_sh = {drem[CW-2:0], dnum[CW-1]};
    ge     = rem_sh >= CW'(dsor);

    first_w  = AW'(first_r);
    stride_w = {{(AW-DB){s_u[DB-1]}}, s_u};

    // Innermost active axis that still has room to advance.
    found = 1'b0;
    sel   = '0;
    for (int i = 0; i < MR; i++) begin
      if ((ssag_pkg::RANK_W'(i) < lat_rank) &&
          ((CW'(counter[i]) + CW'(1)) < count[i])) begin
        found = 1'b1;
        sel   = ssag_pkg::AXIS_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_rank <= ssag_pkg::RANK_W'(1);
      err      <= ssag_pkg::ERR_EMPTY;
      src      <= '0;
      dst      <= '0;
      for (int i = 0; i < MR; i++) counter[i] <= '0;
    end else begin
      unique case (cmd.op)
        ssag_pkg::OP_INIT: begin
          lat_rank <= ssag_pkg::rank_eff(cfg.rank);
          err_z    <= 1'b0;
          err_e    <= 1'b0;
          step     <= AW'(1);
          rew_sum  <= '0;
          base     <= '0;
        end
        ssag_pkg::OP_NORM: begin
          a_n <= a1;
          e_n <= e1;
        end
        ssag_pkg::OP_CLAMP: begin
          first_r <= first_c;
          dnum    <= num_c;
          drem    <= '0;
          dsor    <= s_zero ? DB'(1) : m_u;
          if (s_zero) err_z <= 1'b1;
        end
        ssag_pkg::OP_DIV: begin
          drem <= ge ? (rem_sh - CW'(dsor)) : rem_sh;
          dnum <= {dnum[CW-2:0], ge};
        end
        ssag_pkg::OP_MUL1: begin
          count[cmd.axis] <= dnum;
          if (dnum == '0) err_e <= 1'b1;
          prod <= AW'(first_w * step);
        end
        ssag_pkg::OP_MUL2: begin
          base <= base + prod;
          prod <= AW'(stride_w * step);
        end
        ssag_pkg::OP_MUL3: begin
          // Step of this axis minus the rewind of every faster axis.
          delta[cmd.axis] <= prod - rew_sum;
          prod <= AW'((AW'(dnum) - AW'(1)) * prod);
        end
        ssag_pkg::OP_MUL4: begin
          rew_sum <= rew_sum + prod;
          step    <= AW'(step * AW'(d_u));
        end
        ssag_pkg::OP_DONE: begin
          err <= err_z ? ssag_pkg::ERR_ZERO_STRIDE :
                 (err_e ? ssag_pkg::ERR_EMPTY : ssag_pkg::ERR_OK);
          src <= base;
          dst <= '0;
          for (int i = 0; i < MR; i++) counter[i] <= '0;
        end
        ssag_pkg::OP_EMIT: begin
          if (err != ssag_pkg::ERR_OK) begin
            src_index <= '0;
            dst_index <= '0;
            last      <= 1'b1;
            error     <= err;
          end else begin
            src_index <= src;
            dst_index <= dst;
            last      <= !found;
            error     <= ssag_pkg::ERR_OK;
            src       <= found ? src + delta[sel] : base;
            dst       <= found ? dst + AW'(1) : '0;
            for (int i = 0; i < MR; i++) begin
              if (ssag_pkg::RANK_W'(i) < lat_rank) begin
                if (found && (ssag_pkg::AXIS_W'(i) == sel))
                  counter[i] <= counter[i] + DB'(1);
                else if (!found || (ssag_pkg::AXIS_W'(i) > sel))
                  counter[i] <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/strided_slice_address_gen.sv @@
// ---------------------------------------------------------------------------
// Strided slice address generator
// Gather address walker for a strided slice over up to four tensor axes.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  config    in / out   psel penable pready   paddr pwdata prdata
//  request   in         in_valid / in_stall   restart
//  result    out        out_valid / out_stall src_index dst_index last error
//
// An advance request (restart low) is taken in the idle state; its result
// is registered at that edge, so advances stream at one per cycle unless
// the result stalls, bounded by the single 32-bit add of the running
// source offset. A restart request sets up each axis in turn with a
// normalize step, a clamp step, a bit-serial restoring divider for the
// element count and four 32-bit multiply steps that share one product
// register.
// Reset is synchronous; after reset every advance answers with error 2.
// A stalled result holds the output register and no new request is taken.
// ---------------------------------------------------------------------------
module strided_slice_address_gen (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssag_pkg::CFG_AW-1:0]  paddr,
  input  logic [ssag_pkg::CFG_DW-1:0]  pwdata,
  output logic [ssag_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ssag_pkg::ADDR_W-1:0]  src_index,
  output logic [ssag_pkg::ADDR_W-1:0]  dst_index,
  output logic                         last,
  output logic [ssag_pkg::ERR_W-1:0]   error
);

  // Configuration is only sampled when a restart request sets up a slice.
  ssag_pkg::ssag_cfg_t  cfg;
  // Command and status between the sequencer and the datapath.
  ssag_pkg::ssag_cmd_t  cmd;
  ssag_pkg::ssag_stat_t stat;

  ssag_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller walks the axes from innermost to outermost during setup
  // so that the stride of each axis in elements builds up as it goes.
  ssag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath keeps a per-axis jump for the source offset, so moving to
  // the next element is one add no matter how many axes roll over.
  ssag_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .src_index (src_index),
    .dst_index (dst_index),
    .last      (last),
    .error     (error)
  );

endmodule

@@ hw/rtl/ssag_checker.sv @@
// ---------------------------------------------------------------------------
// Strided slice address generator checker
// Port-level assertions bound to the top level.
// ---------------------------------------------------------------------------
`include "strided_slice_address_gen_assert.svh"

module ssag_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         restart,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ssag_pkg::ADDR_W-1:0]  src_index,
  input logic [ssag_pkg::ADDR_W-1:0]  dst_index,
  input logic                         last,
  input logic [ssag_pkg::ERR_W-1:0]   error
);

  // A stalled result keeps its offsets.
  `SSAG_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(src_index) && $stable(dst_index), "stalled result changed")

  // An error result carries zero offsets and marks the end of the slice.
  `SSAG_ASSERT(a_err_shape, !(out_valid && error != ssag_pkg::ERR_OK) || (src_index == '0 && dst_index == '0 && last), "error result has bad payload")

  // The error code is never above the empty-range code.
  `SSAG_ASSERT(a_err_code, !out_valid || error <= ssag_pkg::ERR_EMPTY, "unused error code")

  // An advance request produces its result in the next cycle.
  `SSAG_ASSERT_NEXT(a_adv_lat, in_valid && !in_stall && !restart, out_valid, "advance result missing")

endmodule

bind strided_slice_address_gen ssag_checker u_ssag_checker (.*);

@@ verif/tb_strided_slice_address_gen.sv @@
// ---------------------------------------------------------------------------
// Strided slice address generator testbench
// Programs slice settings over the register port, streams restart and
// advance requests under varied idling and stalls, and checks every result
// against a cycle-free prediction of the address walk.
// ---------------------------------------------------------------------------
module tb_strided_slice_address_gen;

  typedef struct packed {
    logic [ssag_pkg::ADDR_W-1:0] src;
    logic [ssag_pkg::ADDR_W-1:0] dst;
    logic                        last;
    logic [ssag_pkg::ERR_W-1:0]  err;
  } walk_res_t;

  // Scoreboard: holds the programmed registers, the latched slice and the
  // queue of results that are still owed by the block.
  class slice_scoreboard;
    logic [63:0] dims, starts, ends, strides;
    logic [3:0]  cmask;
    logic [2:0]  rank_reg;
    logic [15:0] ctr [4];
    int          first [4];
    int          count [4];
    int          stride [4];
    logic [31:0] step [4];
    int          act_rank;
    logic [1:0]  slice_err;
    logic [31:0] dst_run;
    walk_res_t   owed [$];
    int          errors;
    int          checked;

    function new();
      dims = 0; starts = 0; ends = 0; strides = 0; cmask = 0; rank_reg = 1;
      for (int i = 0; i < 4; i++) begin
        ctr[i] = 0; first[i] = 0; count[i] = 0; stride[i] = 0; step[i] = 0;
      end
      act_rank = 1; slice_err = ssag_pkg::ERR_EMPTY; dst_run = 0;
      errors = 0; checked = 0;
    endfunction

    function int lane_s(logic [63:0] r, int i);
      logic signed [15:0] v;
      v = r[(3 - i) * 16 +: 16];
      return int'(v);
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        ssag_pkg::REG_DIMS:     dims = v;
        ssag_pkg::REG_STARTS:   starts = v;
        ssag_pkg::REG_ENDS:     ends = v;
        ssag_pkg::REG_STRIDES:  strides = v;
        ssag_pkg::REG_COLLAPSE: cmask = v[3:0];
        ssag_pkg::REG_RANK:     rank_reg = v[2:0];
        default: ;
      endcase
    endfunction

    // Normalize, clamp and count every active axis of a new slice.
    function void load_slice();
      logic [31:0] acc;
      int d, a, e, s, f, c, stop;
      acc = 1;
      act_rank = (rank_reg == 0) ? 1 :
                 (rank_reg > ssag_pkg::MAX_RANK ? ssag_pkg::MAX_RANK : int'(rank_reg));
      slice_err = ssag_pkg::ERR_OK; dst_run = 0;
      for (int i = 0; i < 4; i++) ctr[i] = 0;
      for (int i = 0; i < act_rank; i++)
        if (lane_s(strides, i) == 0) slice_err = ssag_pkg::ERR_ZERO_STRIDE;
      for (int i = act_rank - 1; i >= 0; i--) begin
        d = int'(dims[(3 - i) * 16 +: 16]);
        a = lane_s(starts, i); e = lane_s(ends, i); s = lane_s(strides, i);
        c = 0;
        if (a < 0) a += d;
        if (e < 0 && !(e == -1 && s < 0)) e += d;
        if (cmask[i]) e = (s < 0) ? a - 1 : a + 1;
        if (s > 0) begin
          f = a < 0 ? 0 : (a > d ? d : a);
          stop = e < 0 ? 0 : (e > d ? d : e);
          if (f < stop) c = (stop - f + s - 1) / s;
        end else if (s < 0) begin
          f = a < -1 ? -1 : (a > d - 1 ? d - 1 : a);
          stop = e < -1 ? -1 : (e > d - 1 ? d - 1 : e);
          if (f > stop) c = (f - stop - s - 1) / (-s);
        end else f = 0;
        if (c == 0 && slice_err == ssag_pkg::ERR_OK) slice_err = ssag_pkg::ERR_EMPTY;
        first[i] = f; count[i] = c; stride[i] = s; step[i] = acc;
        acc = acc * 32'(d);
      end
    endfunction

    // An accepted request owes exactly one result.
    function void note_request(logic rs);
      walk_res_t r;
      logic [31:0] pos;
      bit done;
      if (rs) load_slice();
      if (slice_err != ssag_pkg::ERR_OK) begin
        r = '{src: 0, dst: 0, last: 1'b1, err: slice_err};
      end else begin
        r = '{src: 0, dst: dst_run, last: 1'b1, err: ssag_pkg::ERR_OK};
        for (int i = 0; i < act_rank; i++) begin
          pos = 32'(first[i]) + 32'(ctr[i]) * 32'(stride[i]);
          r.src += pos * step[i];
          if (int'(ctr[i]) + 1 != count[i]) r.last = 1'b0;
        end
        done = 0;
        for (int i = act_rank - 1; i >= 0 && !done; i--) begin
          if (int'(ctr[i]) + 1 < count[i]) begin
            ctr[i]++; done = 1;
          end else ctr[i] = 0;
        end
        dst_run = r.last ? 0 : dst_run + 1;
      end
      owed = {owed, r};
    endfunction

    task check_result(walk_res_t got);
      walk_res_t w;
      checked++;
      if (owed.size() == 0) begin
        report("result with nothing owed", 0, 0);
        return;
      end
      w = owed.pop_front();
      if (got.src !== w.src) report("src_index", got.src, w.src);
      if (got.dst !== w.dst) report("dst_index", got.dst, w.dst);
      if (got.last !== w.last) report("last", got.last, w.last);
      if (got.err !== w.err) report("error", got.err, w.err);
    endtask

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %0h want %0h", what, got, want);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ssag_pkg::CFG_AW-1:0] paddr = 0;
  logic [ssag_pkg::CFG_DW-1:0] pwdata = 0, prdata;
  logic pready, in_valid = 0, in_stall, restart = 0, out_valid, out_stall = 0;
  logic [ssag_pkg::ADDR_W-1:0] src_index, dst_index;
  logic last;
  logic [ssag_pkg::ERR_W-1:0] error;

  strided_slice_address_gen dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  slice_scoreboard sb = new();
  int send_idle = 0, stall_pct = 0, hold_off = 0, quiet = 0, sent = 0;
  int restarts = 0, errs_seen = 0;
  localparam int QUIET_LIMIT = 20000;

  // Results are sampled at the rising edge; the stall is redrawn at the
  // falling edge, and a long hold-off is counted here when asked for.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result('{src: src_index, dst: dst_index, last: last, err: error});
      if (error != ssag_pkg::ERR_OK) errs_seen++;
    end
  end
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout with %0d results owed", sb.owed.size());
      $display("tb_strided_slice_address_gen: errors");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ssag_pkg::CFG_AW'(idx) << 3; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Offers one request and holds it until the block takes it. Valid stays
  // high afterwards so that requests can follow back to back; an idle draw
  // or a drain drops it.
  task automatic send(logic rs);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(rs);
    sent++;
    if (rs) restarts++;
    @(negedge clk);
  endtask

  // Stops offering, waits for every owed result, then idles with margin.
  task automatic drain();
    in_valid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] pack4(int a, int b, int c, int d);
    return {16'(a), 16'(b), 16'(c), 16'(d)};
  endfunction

  task automatic load_regs(logic [63:0] di, st, en, sr, logic [3:0] cm, logic [2:0] rk);
    drain();
    reg_write(ssag_pkg::REG_DIMS, di); reg_write(ssag_pkg::REG_STARTS, st);
    reg_write(ssag_pkg::REG_ENDS, en); reg_write(ssag_pkg::REG_STRIDES, sr);
    reg_write(ssag_pkg::REG_COLLAPSE, cm); reg_write(ssag_pkg::REG_RANK, rk);
  endtask

  // Small random slice: sizes stay small so walks are short, with negative
  // indices, reverse strides, collapsed axes and odd ranks mixed in.
  task automatic random_slice();
    int d [4], a [4], e [4], s [4];
    for (int i = 0; i < 4; i++) begin
      d[i] = $urandom_range(1, 6);
      a[i] = $urandom_range(0, 2 * d[i] + 1) - d[i] - 1;
      e[i] = ($urandom_range(4) == 0) ? -1 : $urandom_range(0, 2 * d[i] + 1) - d[i] - 1;
      s[i] = $urandom_range(1, 3);
      if ($urandom_range(2) == 0) s[i] = -s[i];
      if ($urandom_range(40) == 0) s[i] = 0;
    end
    load_regs(pack4(d[0], d[1], d[2], d[3]), pack4(a[0], a[1], a[2], a[3]),
              pack4(e[0], e[1], e[2], e[3]), pack4(s[0], s[1], s[2], s[3]),
              ($urandom_range(3) == 0) ? 4'($urandom) : 4'd0, 3'($urandom_range(0, 7)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Advances before any slice is loaded answer with an empty-range error.
    send(0); send(0);
    // Full forward walk over a 2x3 slice, wrapping past the last element.
    load_regs(pack4(2, 3, 0, 0), 0, pack4(2, 3, 0, 0), pack4(1, 1, 0, 0), 0, 2);
    send(1); repeat (7) send(0);
    // Reverse stride down to index 0 with end -1, and negative starts.
    load_regs(pack4(5, 0, 0, 0), pack4(-1, 0, 0, 0), pack4(-1, 0, 0, 0),
              pack4(-2, 0, 0, 0), 0, 1);
    send(1); repeat (3) send(0);
    // Zero stride error, empty range, collapsed axes and rank extremes.
    load_regs(pack4(3, 3, 3, 3), 0, pack4(3, 3, 3, 3), pack4(1, 0, 1, 1), 0, 4);
    send(1); send(0);
    load_regs(pack4(4, 4, 4, 4), pack4(3, 0, 0, 0), pack4(1, 4, 4, 4),
              pack4(1, 1, 1, 1), 0, 0);
    send(1); send(0);
    load_regs('1, pack4(-32768, 1, 2, 3), pack4(32767, 9, 9, 9),
              pack4(-1, 32767, -32768, 1), 4'hf, 7);
    send(1); send(0);
    load_regs(pack4(3, 4, 2, 5), pack4(1, -1, 0, 4), pack4(3, 0, 2, -6),
              pack4(1, -1, 1, -2), 4'b1010, 3);
    send(1); repeat (2) send(0);

    // Random phases, cycling the idling mix.
    for (int ph = 0; ph < 40; ph++) begin
      random_slice();
      case (ph % 4)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 78; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 78; end
        default: begin send_idle = 25; stall_pct = 25; end
      endcase
      if (ph == 5) hold_off <= 300;
      send(1);
      repeat ($urandom_range(8, 30)) send($urandom_range(15) == 0);
      if (ph == 9) drain();
    end

    drain();
    $display("Covered %0d requests, %0d restarts, %0d error results, %0d checked.",
             sent, restarts, errs_seen, sb.checked);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("tb_strided_slice_address_gen: clean");
    end else begin
      $display("tb_strided_slice_address_gen: errors");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ssag_pkg.sv
hw/rtl/ssag_regs.sv
hw/rtl/ssag_ctrl.sv
hw/rtl/ssag_dp.sv
hw/rtl/strided_slice_address_gen.sv
hw/rtl/ssag_checker.sv
verif/tb_strided_slice_address_gen.sv
